[hdl/ssm_pkg.sv]
`timescale 1ns / 1ps

package ssm_pkg;

    localparam int COUNT_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 4;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      end_of_set;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] descending_value;
        logic signed [VALUE_W-1:0] ascending_value;
        logic signed [VALUE_W-1:0] set_minimum;
        logic signed [VALUE_W-1:0] set_maximum;
        logic                      final_result;
    } out_item_t;

endpackage

[hdl/ssm_ram.sv]
`timescale 1ns / 1ps

module ssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[hdl/small_set_sorter_min_max.sv]
`timescale 1ns / 1ps
// Load: one item per cycle into the element RAM; min/max tracked on the fly.
// Sort: each of the n items is compared against all n items, one compare per cycle
// (limited by the element RAM read ports); ranks address the sorted RAM.
// Emit: after a drain state, each result is read, then loaded once the output is free.
// Reset: synchronous, active low; clears control only, RAMs are not cleared.

module small_set_sorter_min_max #(
    parameter int COUNT = ssm_pkg::COUNT_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ssm_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ssm_pkg::out_item_t m_item
);

    localparam int IW = $clog2(COUNT);
    localparam int CW = $clog2(COUNT + 1);
    localparam int VW = ssm_pkg::VALUE_W;

    typedef enum logic [4:0] {
        S_LOAD    = 5'b00001,
        S_RANK    = 5'b00010,
        S_DRAIN   = 5'b00100,
        S_EMIT_RD = 5'b01000,
        S_EMIT_LD = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [IW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] n_reg, n_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic signed [VW-1:0] min_reg, min_next;
    logic signed [VW-1:0] max_reg, max_next;

    logic          vd_reg, lastd_reg;
    logic [IW-1:0] id_reg, jd_reg;
    logic [IW-1:0] rank_acc_reg;

    logic                 m_valid_reg;
    ssm_pkg::out_item_t   m_item_reg, out_next;

    logic [IW-1:0] last_idx;
    logic          s_acc, out_load, rank_wr, less;
    logic [IW-1:0] rank_cur;
    logic [VW-1:0] st_a, st_b, so_a, so_b;

    assign last_idx = IW'(n_reg - CW'(1));
    assign s_ready  = (state_reg == S_LOAD);
    assign s_acc    = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign out_load = (state_reg == S_EMIT_LD) && (!m_valid_reg || m_ready);

    // element store: written on load, read at (i, j) while ranking
    ssm_ram #(.WIDTH(VW), .DEPTH(COUNT)) u_store (
        .aclk    (aclk),
        .we      (s_acc),
        .waddr   (cnt_reg),
        .wdata   (s_item.value),
        .raddr_a (i_reg),
        .raddr_b (j_reg),
        .rdata_a (st_a),
        .rdata_b (st_b)
    );

    // stable rank: count smaller elements, ties broken by index
    assign less = ($signed(st_b) < $signed(st_a)) || ((st_b == st_a) && (jd_reg < id_reg));
    assign rank_cur = ((jd_reg == '0) ? '0 : rank_acc_reg) + IW'(less);
    assign rank_wr  = vd_reg && lastd_reg;

    ssm_ram #(.WIDTH(VW), .DEPTH(COUNT)) u_sorted (
        .aclk    (aclk),
        .we      (rank_wr),
        .waddr   (rank_cur),
        .wdata   (st_a),
        .raddr_a (k_reg),
        .raddr_b (last_idx - k_reg),
        .rdata_a (so_a),
        .rdata_b (so_b)
    );

    always_comb begin
        out_next.position         = ssm_pkg::POS_W'(k_reg);
        out_next.descending_value = so_b;
        out_next.ascending_value  = so_a;
        out_next.set_minimum      = min_reg;
        out_next.set_maximum      = max_reg;
        out_next.final_result     = (k_reg == last_idx);
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (s_acc) begin
                    if (cnt_reg == '0) begin
                        min_next = s_item.value;
                        max_next = s_item.value;
                    end else begin
                        if (s_item.value < min_reg) min_next = s_item.value;
                        if (s_item.value > max_reg) max_next = s_item.value;
                    end
                    cnt_next = cnt_reg + IW'(1);
                    if (s_item.end_of_set || (cnt_reg == IW'(COUNT - 1))) begin
                        n_next     = CW'(cnt_reg) + CW'(1);
                        cnt_next   = '0;
                        i_next     = '0;
                        j_next     = '0;
                        state_next = S_RANK;
                    end
                end
            end
            S_RANK: begin
                if (j_reg == last_idx) begin
                    j_next = '0;
                    if (i_reg == last_idx) begin
                        state_next = S_DRAIN;
                    end else begin
                        i_next = i_reg + IW'(1);
                    end
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end
            S_DRAIN: begin
                k_next     = '0;
                state_next = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_load) begin
                    if (out_next.final_result) begin
                        state_next = S_LOAD;
                    end else begin
                        k_next     = k_reg + IW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            vd_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vd_reg    <= (state_reg == S_RANK);
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        id_reg       <= i_reg;
        jd_reg       <= j_reg;
        lastd_reg    <= (j_reg == last_idx);
        rank_acc_reg <= rank_cur;
        if (out_load) begin
            m_item_reg <= out_next;
        end
    end

    a_final_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && out_next.final_result |=> state_reg == S_LOAD)
        else $error("final item did not return to load");

    a_rank_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        rank_wr |-> CW'(rank_cur) < n_reg)
        else $error("rank outside set");

    a_value_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> ($signed(so_a) >= min_reg) && ($signed(so_a) <= max_reg)
                  && ($signed(so_b) >= min_reg) && ($signed(so_b) <= max_reg))
        else $error("sorted value outside min/max");

endmodule

[verif/tb_small_set_sorter_min_max.sv]
`timescale 1ns / 1ps

module tb_small_set_sorter_min_max;

    localparam int SET_CAP    = ssm_pkg::COUNT_DEFAULT;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 400;
    localparam int DRAIN      = 50;
    localparam int RAND_ITEMS = 220;

    class sort_scoreboard;
        int                 errors;
        int                 open_set[$];
        ssm_pkg::out_item_t sorted_q[$];

        function void note_input(ssm_pkg::in_item_t it);
            int ranked[$];
            int n;
            int key;
            int j;
            ssm_pkg::out_item_t r;
            open_set.push_back(int'(it.value));
            if (!it.end_of_set && open_set.size() < SET_CAP) return;
            ranked = open_set;
            n = ranked.size();
            for (int i = 1; i < n; i++) begin
                key = ranked[i];
                j = i;
                while (j > 0 && key < ranked[j-1]) begin
                    ranked[j] = ranked[j-1];
                    j--;
                end
                ranked[j] = key;
            end
            for (int i = 0; i < n; i++) begin
                r.position         = ssm_pkg::POS_W'(i);
                r.descending_value = ranked[n-1-i];
                r.ascending_value  = ranked[i];
                r.set_minimum      = ranked[0];
                r.set_maximum      = ranked[n-1];
                r.final_result     = (i == n - 1);
                sorted_q.push_back(r);
            end
            open_set.delete();
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
                errors++;
            end
        endfunction

        function void check_result(ssm_pkg::out_item_t got);
            ssm_pkg::out_item_t want;
            if (sorted_q.size() == 0) begin
                $error("unexpected item: position %0d value %0d",
                       got.position, got.ascending_value);
                errors++;
                return;
            end
            want = sorted_q.pop_front();
            cmp("position", 32'(want.position), 32'(got.position));
            cmp("descending_value", want.descending_value, got.descending_value);
            cmp("ascending_value", want.ascending_value, got.ascending_value);
            cmp("set_minimum", want.set_minimum, got.set_minimum);
            cmp("set_maximum", want.set_maximum, got.set_maximum);
            cmp("final_result", 32'(want.final_result), 32'(got.final_result));
        endfunction

        function int pending();
            return sorted_q.size();
        endfunction
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    ssm_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    ssm_pkg::out_item_t m_item;

    sort_scoreboard sb = new();
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_done = 1'b0;

    small_set_sorter_min_max dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_item);
            if (m_valid && m_ready) sb.check_result(m_item);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_small_set_sorter_min_max: FAIL");
                $finish;
            end
        end
    end

    // receiver: short random stalls, one long hold-off to back up the input
    initial begin
        int n;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!hold_done && items_sent >= 60) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 10);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input ssm_pkg::in_item_t it);
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_set(input int vals[$], input bit mark_end);
        ssm_pkg::in_item_t it;
        for (int i = 0; i < vals.size(); i++) begin
            it.value      = vals[i];
            it.end_of_set = mark_end && (i == vals.size() - 1);
            send_item(it);
        end
    endtask

    function automatic int pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel) inside
            0: return int'(32'h8000_0000);
            1: return int'(32'h7fff_ffff);
            2: return 0;
            3: return -1;
            4, 5: return $urandom_range(0, 6) - 3;
            default: return int'($urandom());
        endcase
    endfunction

    initial begin
        int vals[$];
        int size;
        int sel;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-element sets at both extremes
        vals = {int'(32'h8000_0000)};
        send_set(vals, 1'b1);
        vals = {int'(32'h7fff_ffff)};
        send_set(vals, 1'b1);
        // extremes and duplicates
        vals = {0, -1, int'(32'h7fff_ffff), int'(32'h8000_0000), 5, 5};
        send_set(vals, 1'b1);
        // full set closed by count, no end marker
        vals = {int'(32'haaaa_aaaa), int'(32'h5555_5555), 7, -7, 7, 3, 100000, -100000,
                0, 1, -2, int'(32'h7fff_fffe), int'(32'h8000_0001), 12, 12, 42};
        send_set(vals, 1'b0);

        while (items_sent < RAND_ITEMS) begin
            if (items_sent >= RAND_ITEMS - 40) quiet = 1'b1;
            sel = $urandom_range(0, 9);
            if (sel == 0) size = SET_CAP;
            else if (sel < 3) size = $urandom_range(7, SET_CAP - 1);
            else size = $urandom_range(1, 6);
            vals.delete();
            for (int i = 0; i < size; i++) vals.push_back(pick_value());
            send_set(vals, (size < SET_CAP) ? 1'b1 : 1'($urandom_range(0, 1)));
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb_small_set_sorter_min_max: PASS");
        end else begin
            $display("tb_small_set_sorter_min_max: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
hdl/ssm_pkg.sv
hdl/ssm_ram.sv
hdl/small_set_sorter_min_max.sv
verif/tb_small_set_sorter_min_max.sv
